// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for annexb_parameter_set_locator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define APSL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
`define APSL_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define APSL_ASSERT(lbl, clk, rst_n, prop)
`define APSL_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/apsl_pkg.sv =====
package apsl_pkg;

    localparam int MAX_INPUT_DEF = 2048;

    localparam int BYTE_W = 8;
    localparam int CAP_W  = 12;
    localparam int OFF_W  = 11;
    localparam int LEN_W  = 12;
    localparam int TOT_W  = 13;
    localparam int IDX_W  = 2;

    localparam logic [TOT_W-1:0] TOTAL_CAP = 13'd4096;
    localparam logic [CAP_W-1:0] CAP_RESET = 12'd256;

    // nal header masks
    localparam logic [7:0] H265_TYPE_MASK = 8'h7E;
    localparam logic [7:0] H265_HDR1_ZERO = 8'h81;
    localparam logic [7:0] H265_HDR2_ZERO = 8'hF8;

    localparam logic [4:0] H264_TYPE_SPS = 5'd7;
    localparam logic [4:0] H264_TYPE_PPS = 5'd8;
    localparam logic [5:0] H265_TYPE_VPS = 6'd32;
    localparam logic [5:0] H265_TYPE_SPS = 6'd33;
    localparam logic [5:0] H265_TYPE_PPS = 6'd34;

    typedef enum logic [1:0] {
        MODE_H264 = 2'd0,
        MODE_H265 = 2'd1,
        MODE_AV1  = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE    = 2'd0,
        REG_VPS_CAP = 2'd1,
        REG_SPS_CAP = 2'd2,
        REG_PPS_CAP = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_VPS  = 2'd0,
        KIND_SPS  = 2'd1,
        KIND_PPS  = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    // outcome of closing one unit
    typedef struct packed {
        logic  hit;
        logic  err;
        t_kind kind;
    } t_close;

endpackage

// ===== hw/rtl/apsl_byte_if.sv =====
interface apsl_byte_if;
    logic                         valid;
    logic                         ready;
    logic [apsl_pkg::BYTE_W-1:0]  data_byte;
    logic                         last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink (input valid, data_byte, last_byte, output ready);
endinterface

// ===== hw/rtl/apsl_res_if.sv =====
interface apsl_res_if;
    logic                        valid;
    logic                        ready;
    logic [apsl_pkg::OFF_W-1:0]  vps_offset;
    logic [apsl_pkg::LEN_W-1:0]  vps_length;
    logic [apsl_pkg::OFF_W-1:0]  sps_offset;
    logic [apsl_pkg::LEN_W-1:0]  sps_length;
    logic [apsl_pkg::OFF_W-1:0]  pps_offset;
    logic [apsl_pkg::LEN_W-1:0]  pps_length;
    logic                        status;

    modport source (
        output valid, vps_offset, vps_length, sps_offset, sps_length,
               pps_offset, pps_length, status,
        input  ready
    );
    modport sink (
        input  valid, vps_offset, vps_length, sps_offset, sps_length,
               pps_offset, pps_length, status,
        output ready
    );
endinterface

// ===== hw/rtl/apsl_close.sv =====
module apsl_close #(
    parameter int LW = apsl_pkg::LEN_W
) (
    input  apsl_pkg::t_mode              i_mode,
    input  logic [apsl_pkg::CAP_W-1:0]   i_vps_cap,
    input  logic [apsl_pkg::CAP_W-1:0]   i_sps_cap,
    input  logic [apsl_pkg::CAP_W-1:0]   i_pps_cap,
    input  logic [LW-1:0]                i_start,
    input  logic [LW-1:0]                i_end,
    input  logic                         i_code4,
    input  logic [7:0]                   i_hdr1,
    input  logic [7:0]                   i_hdr2,
    output apsl_pkg::t_close             o_res,
    output logic [apsl_pkg::OFF_W-1:0]   o_off,
    output logic [apsl_pkg::LEN_W-1:0]   o_len
);

    logic [LW-1:0]                len;
    logic [LW-1:0]                code_len;
    logic [4:0]                   t264;
    logic [5:0]                   t265;
    logic [apsl_pkg::CAP_W-1:0]   cap;
    apsl_pkg::t_kind              kind;
    logic                         over;

    assign len      = i_end - i_start;
    assign code_len = i_code4 ? LW'(4) : LW'(3);
    assign t264     = i_hdr1[4:0];
    assign t265     = 6'((i_hdr1 & apsl_pkg::H265_TYPE_MASK) >> 1);

    always_comb begin
        kind = apsl_pkg::KIND_NONE;
        if (len > LW'(3)) begin
            unique case (i_mode)
                apsl_pkg::MODE_H264: begin
                    if (len >= code_len + LW'(1)) begin
                        if (t264 == apsl_pkg::H264_TYPE_SPS) begin
                            kind = apsl_pkg::KIND_SPS;
                        end else if (t264 == apsl_pkg::H264_TYPE_PPS) begin
                            kind = apsl_pkg::KIND_PPS;
                        end
                    end
                end
                apsl_pkg::MODE_H265: begin
                    // forbidden and layer id bits must be clear
                    if (len >= code_len + LW'(2)
                            && (i_hdr1 & apsl_pkg::H265_HDR1_ZERO) == 8'h00
                            && (i_hdr2 & apsl_pkg::H265_HDR2_ZERO) == 8'h00) begin
                        if (t265 == apsl_pkg::H265_TYPE_VPS) begin
                            kind = apsl_pkg::KIND_VPS;
                        end else if (t265 == apsl_pkg::H265_TYPE_SPS) begin
                            kind = apsl_pkg::KIND_SPS;
                        end else if (t265 == apsl_pkg::H265_TYPE_PPS) begin
                            kind = apsl_pkg::KIND_PPS;
                        end
                    end
                end
                apsl_pkg::MODE_AV1, apsl_pkg::MODE_NONE: begin
                    kind = apsl_pkg::KIND_NONE;
                end
                default: kind = apsl_pkg::KIND_NONE;
            endcase
        end
    end

    always_comb begin
        unique case (kind)
            apsl_pkg::KIND_VPS: cap = i_vps_cap;
            apsl_pkg::KIND_SPS: cap = i_sps_cap;
            apsl_pkg::KIND_PPS: cap = i_pps_cap;
            default:            cap = '0;
        endcase
    end

    assign over       = len > LW'(cap);
    assign o_res.kind = kind;
    assign o_res.hit  = (kind != apsl_pkg::KIND_NONE) && !over;
    assign o_res.err  = (kind != apsl_pkg::KIND_NONE) && over;
    assign o_off      = i_start[apsl_pkg::OFF_W-1:0];
    assign o_len      = len[apsl_pkg::LEN_W-1:0];

endmodule

// ===== hw/rtl/annexb_parameter_set_locator.sv =====
// channel   dir  beat payload                                 ends on
// i_byte    in   data_byte, last_byte                         valid & ready
// o_res     out  vps/sps/pps offset and length, status        valid & ready
// i_cfg_*   in   register index, write data                   i_cfg_we
//
// one byte per cycle unless a last byte waits for a busy output register: a beat is registered, then parsed
// a last_byte beat goes to the input register, then its result to the output register once that is free
// a pending result only stalls the input when the next parsed byte is also a last byte
// i_rst_n is synchronous; reset clears the parse state and sets capacities to 256
`include "assert_macros.svh"

module annexb_parameter_set_locator #(
    parameter int MAX_INPUT = apsl_pkg::MAX_INPUT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [apsl_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [apsl_pkg::CAP_W-1:0]    i_cfg_data,
    apsl_byte_if.sink                     i_byte,
    apsl_res_if.source                    o_res
);

    localparam int PW = $clog2(MAX_INPUT + 1);
    localparam int LW = (PW > apsl_pkg::LEN_W) ? PW : apsl_pkg::LEN_W;
    localparam int OW = apsl_pkg::OFF_W;
    localparam int NW = apsl_pkg::LEN_W;

    // configuration
    apsl_pkg::t_mode              r_mode;
    logic [apsl_pkg::CAP_W-1:0]   r_vps_cap, r_sps_cap, r_pps_cap;

    // input register
    logic                         r_iv;
    logic [7:0]                   r_ib;
    logic                         r_il;

    // parse state
    logic [23:0]   r_win,    n_win;
    logic [1:0]    r_fill,   n_fill;
    logic [PW-1:0] r_pos,    n_pos;
    logic          r_inside, n_inside;
    logic [PW-1:0] r_start,  n_start;
    logic          r_code4,  n_code4;
    logic [7:0]    r_h1,     n_h1;
    logic [7:0]    r_h2,     n_h2;
    logic [1:0]    r_hseen,  n_hseen;
    logic [OW-1:0] r_off [0:2];
    logic [OW-1:0] n_off [0:2];
    logic [NW-1:0] r_len [0:2];
    logic [NW-1:0] n_len [0:2];
    logic          r_err,    n_err;
    logic [1:0]    r_skip,   n_skip;
    logic [apsl_pkg::TOT_W-1:0] r_total, n_total;

    // output register
    logic          r_ov;
    logic [OW-1:0] r_o_vps_off, r_o_sps_off, r_o_pps_off;
    logic [NW-1:0] r_o_vps_len, r_o_sps_len, r_o_pps_len;
    logic          r_o_status;

    logic          out_free;
    logic          proc;
    logic          parse;
    logic          chk;
    logic          four;
    logic          three;
    logic          det;
    logic [PW:0]   hdr_pos;
    logic [PW:0]   n_code_len;

    apsl_pkg::t_close a_res, b_res;
    logic [OW-1:0] a_off, b_off;
    logic [NW-1:0] a_len, b_len;
    logic [LW-1:0] a_start, a_end, b_start, b_end;
    logic          b_en;

    logic          f_err;
    logic [OW-1:0] f_off [0:2];
    logic [NW-1:0] f_len [0:2];
    logic [OW-1:0] res_vps_off, res_sps_off, res_pps_off;
    logic [NW-1:0] res_vps_len, res_sps_len, res_pps_len;
    logic          res_status;

    assign out_free    = !r_ov || o_res.ready;
    assign proc        = r_iv && (!r_il || out_free);
    assign i_byte.ready = !r_iv || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= apsl_pkg::MODE_H264;
            r_vps_cap <= apsl_pkg::CAP_RESET;
            r_sps_cap <= apsl_pkg::CAP_RESET;
            r_pps_cap <= apsl_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            unique case (apsl_pkg::t_reg_idx'(i_cfg_idx))
                apsl_pkg::REG_MODE:    r_mode    <= apsl_pkg::t_mode'(i_cfg_data[1:0]);
                apsl_pkg::REG_VPS_CAP: r_vps_cap <= i_cfg_data;
                apsl_pkg::REG_SPS_CAP: r_sps_cap <= i_cfg_data;
                apsl_pkg::REG_PPS_CAP: r_pps_cap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_byte.ready) begin
            r_iv <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_ib <= i_byte.data_byte;
            r_il <= i_byte.last_byte;
        end
    end

    // start code search over the three previous bytes and the current one
    assign parse = !r_err && (r_pos < PW'(MAX_INPUT));
    assign chk   = parse && (r_fill == 2'd3) && (r_skip == 2'd0);
    assign four  = (r_win == 24'h000000) && (r_ib == 8'h01);
    assign three = (r_win[23:8] == 16'h0000) && (r_win[7:0] == 8'h01);
    assign det   = chk && (four || three);

    // close of the open unit when a new start code shows up
    assign a_start = LW'(r_start);
    assign a_end   = LW'(r_pos) - LW'(3);

    apsl_close #(.LW(LW)) u_close_code (
        .i_mode    (r_mode),
        .i_vps_cap (r_vps_cap),
        .i_sps_cap (r_sps_cap),
        .i_pps_cap (r_pps_cap),
        .i_start   (a_start),
        .i_end     (a_end),
        .i_code4   (r_code4),
        .i_hdr1    (r_h1),
        .i_hdr2    (r_h2),
        .o_res     (a_res),
        .o_off     (a_off),
        .o_len     (a_len)
    );

    always_comb begin
        n_win    = r_win;
        n_fill   = r_fill;
        n_pos    = r_pos;
        n_inside = r_inside;
        n_start  = r_start;
        n_code4  = r_code4;
        n_h1     = r_h1;
        n_h2     = r_h2;
        n_hseen  = r_hseen;
        n_off    = r_off;
        n_len    = r_len;
        n_err    = r_err;
        n_skip   = r_skip;
        n_total  = (r_total < apsl_pkg::TOTAL_CAP) ? r_total + 1'b1 : r_total;
        n_code_len = '0;
        hdr_pos    = '0;

        if (parse) begin
            if (r_fill == 2'd3 && r_skip != 2'd0) begin
                n_skip = r_skip - 2'd1;
            end
            if (det) begin
                if (r_inside) begin
                    for (int k = 0; k < 3; k++) begin
                        if (a_res.hit && a_res.kind == apsl_pkg::t_kind'(k)) begin
                            n_off[k] = a_off;
                            n_len[k] = a_len;
                        end
                    end
                    if (a_res.err) begin
                        n_err = 1'b1;
                    end
                end
                n_inside = 1'b1;
                n_start  = r_pos - PW'(3);
                n_code4  = four;
                n_hseen  = 2'd0;
                n_h1     = 8'h00;
                n_h2     = 8'h00;
                n_skip   = four ? 2'd3 : 2'd2;
            end
            // header bytes sit right after the start code
            n_code_len = n_code4 ? (PW+1)'(4) : (PW+1)'(3);
            hdr_pos    = (PW+1)'(n_start) + n_code_len + (PW+1)'(n_hseen);
            if (n_inside && n_hseen < 2'd2 && (PW+1)'(r_pos) == hdr_pos) begin
                if (n_hseen == 2'd0) begin
                    n_h1 = r_ib;
                end else begin
                    n_h2 = r_ib;
                end
                n_hseen = n_hseen + 2'd1;
            end
            n_win = {r_win[15:0], r_ib};
            if (r_fill != 2'd3) begin
                n_fill = r_fill + 2'd1;
            end
            n_pos = r_pos + PW'(1);
        end
    end

    // close of the open unit at the end of the blob
    assign b_start = LW'(n_start);
    assign b_end   = LW'(n_pos);
    assign b_en    = !n_err && n_inside;

    apsl_close #(.LW(LW)) u_close_end (
        .i_mode    (r_mode),
        .i_vps_cap (r_vps_cap),
        .i_sps_cap (r_sps_cap),
        .i_pps_cap (r_pps_cap),
        .i_start   (b_start),
        .i_end     (b_end),
        .i_code4   (n_code4),
        .i_hdr1    (n_h1),
        .i_hdr2    (n_h2),
        .o_res     (b_res),
        .o_off     (b_off),
        .o_len     (b_len)
    );

    always_comb begin
        f_err = n_err || (b_en && b_res.err);
        f_off = n_off;
        f_len = n_len;
        for (int k = 0; k < 3; k++) begin
            if (b_en && b_res.hit && b_res.kind == apsl_pkg::t_kind'(k)) begin
                f_off[k] = b_off;
                f_len[k] = b_len;
            end
        end
    end

    always_comb begin
        res_vps_off = '0;
        res_sps_off = '0;
        res_pps_off = '0;
        res_vps_len = '0;
        res_sps_len = '0;
        res_pps_len = '0;
        res_status  = 1'b0;
        unique case (r_mode)
            apsl_pkg::MODE_H264, apsl_pkg::MODE_H265: begin
                if (f_err) begin
                    res_status = 1'b1;
                end else begin
                    res_vps_off = f_off[apsl_pkg::KIND_VPS];
                    res_vps_len = f_len[apsl_pkg::KIND_VPS];
                    res_sps_off = f_off[apsl_pkg::KIND_SPS];
                    res_sps_len = f_len[apsl_pkg::KIND_SPS];
                    res_pps_off = f_off[apsl_pkg::KIND_PPS];
                    res_pps_len = f_len[apsl_pkg::KIND_PPS];
                end
            end
            apsl_pkg::MODE_AV1: begin
                // whole blob is the sequence header
                if (n_total > apsl_pkg::TOT_W'(r_sps_cap)) begin
                    res_status = 1'b1;
                end else begin
                    res_sps_len = n_total[NW-1:0];
                end
            end
            apsl_pkg::MODE_NONE: res_status = 1'b0;
            default:             res_status = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proc && r_il)) begin
            r_win    <= '0;
            r_fill   <= '0;
            r_pos    <= '0;
            r_inside <= 1'b0;
            r_start  <= '0;
            r_code4  <= 1'b0;
            r_h1     <= '0;
            r_h2     <= '0;
            r_hseen  <= '0;
            r_err    <= 1'b0;
            r_skip   <= '0;
            r_total  <= '0;
            for (int k = 0; k < 3; k++) begin
                r_off[k] <= '0;
                r_len[k] <= '0;
            end
        end else if (proc) begin
            r_win    <= n_win;
            r_fill   <= n_fill;
            r_pos    <= n_pos;
            r_inside <= n_inside;
            r_start  <= n_start;
            r_code4  <= n_code4;
            r_h1     <= n_h1;
            r_h2     <= n_h2;
            r_hseen  <= n_hseen;
            r_err    <= n_err;
            r_skip   <= n_skip;
            r_total  <= n_total;
            r_off    <= n_off;
            r_len    <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (proc && r_il) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_il) begin
            r_o_vps_off <= res_vps_off;
            r_o_vps_len <= res_vps_len;
            r_o_sps_off <= res_sps_off;
            r_o_sps_len <= res_sps_len;
            r_o_pps_off <= res_pps_off;
            r_o_pps_len <= res_pps_len;
            r_o_status  <= res_status;
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.vps_offset = r_o_vps_off;
    assign o_res.vps_length = r_o_vps_len;
    assign o_res.sps_offset = r_o_sps_off;
    assign o_res.sps_length = r_o_sps_len;
    assign o_res.pps_offset = r_o_pps_off;
    assign o_res.pps_length = r_o_pps_len;
    assign o_res.status     = r_o_status;

    `APSL_ASSERT(a_res_from_last, i_clk, i_rst_n, $rose(r_ov) |-> $past(r_iv && r_il))
    `APSL_ASSERT(a_err_no_len, i_clk, i_rst_n,
        (r_ov && r_o_status)
            |-> (r_o_vps_len == '0 && r_o_sps_len == '0 && r_o_pps_len == '0))
    `APSL_ASSERT(a_skip_full_win, i_clk, i_rst_n, (r_skip != 2'd0) |-> (r_fill == 2'd3))
    `APSL_NEVER(a_hseen_range, i_clk, i_rst_n, r_hseen == 2'd3)
    `APSL_ASSERT(a_clear_after_last, i_clk, i_rst_n,
        (proc && r_il) |=> (r_pos == '0 && !r_inside && !r_err))

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    import apsl_pkg::*;

    localparam int MAX_IN = MAX_INPUT_DEF;
    localparam int N_DIR = 30;
    localparam int RAND_ITEMS = 700;
    localparam int MIN_BLOBS = 40;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        logic [OFF_W-1:0] vps_off;
        logic [LEN_W-1:0] vps_len;
        logic [OFF_W-1:0] sps_off;
        logic [LEN_W-1:0] sps_len;
        logic [OFF_W-1:0] pps_off;
        logic [LEN_W-1:0] pps_len;
        logic             status;
    } t_ps_locs;

    typedef struct {
        bit           is_cfg;
        t_reg_idx     idx;
        logic [11:0]  val;
        logic [7:0]   b;
        logic         last;
        bit           typed;
        t_ps_locs     res;
    } t_dir_row;

    localparam t_ps_locs NO_UNITS = '0;
    localparam t_ps_locs OVERFLOW_ONLY = '{status: 1'b1, default: '0};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [CAP_W-1:0] i_cfg_data = '0;

    apsl_byte_if byte_ch ();
    apsl_res_if  res_ch ();

    annexb_parameter_set_locator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_byte     (byte_ch),
        .o_res      (res_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ---------------- locator model ----------------
    t_mode       cfg_mode;
    logic [11:0] cfg_cap [3];

    logic [23:0] win;
    logic [1:0]  win_fill;
    logic [11:0] parse_pos;
    logic        in_unit;
    logic [11:0] unit_pos;
    logic [2:0]  sc_len;
    logic [7:0]  nal_hdr1;
    logic [7:0]  nal_hdr2;
    logic [1:0]  hdr_cnt;
    logic [10:0] sel_off [3];
    logic [11:0] sel_len [3];
    logic        overflow;
    logic [1:0]  skip_cnt;
    logic [12:0] blob_total;

    function automatic void clear_parse();
        win = '0;
        win_fill = '0;
        parse_pos = '0;
        in_unit = 1'b0;
        unit_pos = '0;
        sc_len = '0;
        nal_hdr1 = '0;
        nal_hdr2 = '0;
        hdr_cnt = '0;
        for (int k = 0; k < 3; k++) begin
            sel_off[k] = '0;
            sel_len[k] = '0;
        end
        overflow = 1'b0;
        skip_cnt = '0;
        blob_total = '0;
    endfunction

    function automatic t_kind unit_kind(input logic [11:0] len);
        logic [5:0] t265;
        if (len <= 12'd3) return KIND_NONE;
        case (cfg_mode)
            MODE_H264: begin
                if (len < sc_len + 12'd1) return KIND_NONE;
                if (nal_hdr1[4:0] == H264_TYPE_SPS) return KIND_SPS;
                if (nal_hdr1[4:0] == H264_TYPE_PPS) return KIND_PPS;
                return KIND_NONE;
            end
            MODE_H265: begin
                if (len < sc_len + 12'd2) return KIND_NONE;
                if ((nal_hdr1 & H265_HDR1_ZERO) != 8'd0 || (nal_hdr2 & H265_HDR2_ZERO) != 8'd0)
                    return KIND_NONE;
                t265 = nal_hdr1[6:1];
                if (t265 == H265_TYPE_VPS) return KIND_VPS;
                if (t265 == H265_TYPE_SPS) return KIND_SPS;
                if (t265 == H265_TYPE_PPS) return KIND_PPS;
                return KIND_NONE;
            end
            default: return KIND_NONE;
        endcase
    endfunction

    function automatic void close_unit(input logic [11:0] end_pos);
        logic [11:0] len;
        t_kind k;
        len = end_pos - unit_pos;
        k = unit_kind(len);
        if (k == KIND_NONE) return;
        if (len > cfg_cap[k]) begin
            overflow = 1'b1;
        end else begin
            sel_off[k] = unit_pos[10:0];
            sel_len[k] = len;
        end
    endfunction

    // returns 1 when the byte closes a blob and a result is due
    function automatic bit locate_step(input logic [7:0] b, input logic last,
                                       output t_ps_locs r);
        logic [2:0]  code;
        logic [11:0] p;
        r = '0;
        if (blob_total < TOTAL_CAP) blob_total++;
        if (!overflow && parse_pos < MAX_IN) begin
            p = parse_pos;
            if (win_fill == 2'd3) begin
                if (skip_cnt != 2'd0) begin
                    skip_cnt--;
                end else begin
                    if (win == 24'd0 && b == 8'h01) code = 3'd4;
                    else if (win[23:8] == 16'd0 && win[7:0] == 8'h01) code = 3'd3;
                    else code = 3'd0;
                    if (code != 3'd0) begin
                        if (in_unit) close_unit(p - 12'd3);
                        in_unit = 1'b1;
                        unit_pos = p - 12'd3;
                        sc_len = code;
                        hdr_cnt = '0;
                        nal_hdr1 = '0;
                        nal_hdr2 = '0;
                        skip_cnt = 2'(code - 3'd1);
                    end
                end
            end
            if (in_unit && hdr_cnt < 2'd2 && p == unit_pos + sc_len + hdr_cnt) begin
                if (hdr_cnt == 2'd0) nal_hdr1 = b;
                else nal_hdr2 = b;
                hdr_cnt++;
            end
            win = {win[15:0], b};
            if (win_fill < 2'd3) win_fill++;
            parse_pos++;
        end
        if (!last) return 1'b0;
        if (cfg_mode == MODE_H264 || cfg_mode == MODE_H265) begin
            if (!overflow && in_unit) close_unit(parse_pos);
            if (overflow) begin
                r.status = 1'b1;
            end else begin
                r.vps_off = sel_off[KIND_VPS];
                r.vps_len = sel_len[KIND_VPS];
                r.sps_off = sel_off[KIND_SPS];
                r.sps_len = sel_len[KIND_SPS];
                r.pps_off = sel_off[KIND_PPS];
                r.pps_len = sel_len[KIND_PPS];
            end
        end else if (cfg_mode == MODE_AV1) begin
            if (blob_total > {1'b0, cfg_cap[KIND_SPS]}) r.status = 1'b1;
            else r.sps_len = blob_total[11:0];
        end
        clear_parse();
        return 1'b1;
    endfunction

    // ---------------- result checking ----------------
    t_ps_locs expected_locs [$];
    int       mismatch_cnt = 0;
    bit       drv_typed = 1'b0;
    t_ps_locs drv_typed_res = '0;
    string    loc_field_name [7] = '{"vps_offset", "vps_length", "sps_offset",
                                     "sps_length", "pps_offset", "pps_length", "status"};

    function automatic void flag(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("mismatch: %s", msg);
    endfunction

    always @(posedge i_clk) begin
        t_ps_locs pred;
        t_ps_locs want;
        t_ps_locs got;
        bit has_res;
        int e_f [7];
        int g_f [7];
        if (!i_rst_n) begin
            cfg_mode = MODE_H264;
            for (int k = 0; k < 3; k++) cfg_cap[k] = CAP_RESET;
            clear_parse();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_MODE:    cfg_mode = t_mode'(i_cfg_data[1:0]);
                    REG_VPS_CAP: cfg_cap[KIND_VPS] = i_cfg_data;
                    REG_SPS_CAP: cfg_cap[KIND_SPS] = i_cfg_data;
                    REG_PPS_CAP: cfg_cap[KIND_PPS] = i_cfg_data;
                endcase
            end
            if (byte_ch.valid && byte_ch.ready) begin
                has_res = locate_step(byte_ch.data_byte, byte_ch.last_byte, pred);
                if (has_res) expected_locs.push_back(drv_typed ? drv_typed_res : pred);
            end
            if (res_ch.valid && res_ch.ready) begin
                got = {res_ch.vps_offset, res_ch.vps_length, res_ch.sps_offset,
                       res_ch.sps_length, res_ch.pps_offset, res_ch.pps_length,
                       res_ch.status};
                if (expected_locs.size() == 0) begin
                    flag($sformatf("result beat with nothing expected, status %0d",
                                   res_ch.status));
                end else begin
                    want = expected_locs.pop_front();
                    e_f = '{int'(want.vps_off), int'(want.vps_len), int'(want.sps_off),
                            int'(want.sps_len), int'(want.pps_off), int'(want.pps_len),
                            int'(want.status)};
                    g_f = '{int'(got.vps_off), int'(got.vps_len), int'(got.sps_off),
                            int'(got.sps_len), int'(got.pps_off), int'(got.pps_len),
                            int'(got.status)};
                    for (int f = 0; f < 7; f++) begin
                        if (e_f[f] != g_f[f])
                            flag($sformatf("%s expected %0d, got %0d",
                                           loc_field_name[f], e_f[f], g_f[f]));
                    end
                end
            end
        end
    end

    // ---------------- result side stalls ----------------
    int rx_style = 0;
    int rx_left = 0;
    int rx_stall = 0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 120);
        end
        rx_left--;
        case (rx_style)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= !res_ch.ready;
            2: res_ch.ready <= 1'($urandom);
            default: begin
                if (rx_stall != 0) begin
                    res_ch.ready <= 1'b0;
                    rx_stall--;
                end else begin
                    res_ch.ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) rx_stall = $urandom_range(1, 24);
                end
            end
        endcase
    end

    // ---------------- byte side ----------------
    bit   gap_on = 1'b1;
    int   burst_max = 3;
    int   gap_max = 2;
    int   burst_left = 0;
    int   rand_items = 0;
    logic [7:0] blob_q [$];

    task automatic send_beat(input logic [7:0] b, input logic last, input bit typed,
                             input t_ps_locs tres);
        if (gap_on) begin
            if (burst_left == 0) begin
                byte_ch.valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
                burst_left = $urandom_range(1, burst_max);
            end
            burst_left--;
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= last;
        drv_typed <= typed;
        drv_typed_res <= tres;
        do @(posedge i_clk); while (!(byte_ch.valid && byte_ch.ready));
        @(negedge i_clk);
    endtask

    // hold the sender until every result is back, then let the pipe empty
    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (expected_locs.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [11:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic retune();
        logic [11:0] cap_v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: cfg_write(REG_MODE, 12'(MODE_H264));
            4, 5, 6, 7: cfg_write(REG_MODE, 12'(MODE_H265));
            8:          cfg_write(REG_MODE, 12'(MODE_AV1));
            default:    cfg_write(REG_MODE, 12'(MODE_NONE));
        endcase
        for (int k = 1; k < 4; k++) begin
            case ($urandom_range(0, 7))
                0: cap_v = 12'd0;
                1: cap_v = 12'd2048;
                2: cap_v = CAP_RESET;
                3: cap_v = 12'($urandom_range(1, 16));
                4: cap_v = 12'($urandom_range(4, 40));
                default: cap_v = 12'($urandom_range(20, 2048));
            endcase
            cfg_write(t_reg_idx'(k), cap_v);
        end
    endtask

    // min_len > 0 asks for a well-formed blob of at least that many bytes
    function automatic void build_blob(input int min_len);
        int shape;
        int units_left;
        int pay;
        int n_hdr;
        int cut;
        bit as_265;
        logic [4:0] t5;
        logic [5:0] t6;
        logic [7:0] h1;
        logic [7:0] h2;
        blob_q.delete();
        shape = (min_len > 0) ? 3 : $urandom_range(0, 9);
        if (shape == 0) begin
            // zero-heavy noise, start codes appear by chance
            repeat ($urandom_range(1, 24)) begin
                case ($urandom_range(0, 3))
                    0, 1: blob_q.push_back(8'h00);
                    2: blob_q.push_back(8'h01);
                    default: blob_q.push_back(8'($urandom));
                endcase
            end
            return;
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) blob_q.push_back(8'($urandom_range(2, 255)));
        units_left = $urandom_range(1, 4);
        while (units_left > 0 || blob_q.size() < min_len) begin
            if ($urandom_range(0, 1) == 1) blob_q.push_back(8'h00);
            blob_q.push_back(8'h00);
            blob_q.push_back(8'h00);
            blob_q.push_back(8'h01);
            as_265 = (cfg_mode == MODE_H265) ^ ($urandom_range(0, 4) == 0);
            if (as_265) begin
                case ($urandom_range(0, 4))
                    0: t6 = H265_TYPE_VPS;
                    1: t6 = H265_TYPE_SPS;
                    2: t6 = H265_TYPE_PPS;
                    default: t6 = 6'($urandom);
                endcase
                h1 = {($urandom_range(0, 9) == 0), t6, ($urandom_range(0, 9) == 0)};
                h2 = {(($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'd0), 3'($urandom)};
            end else begin
                case ($urandom_range(0, 3))
                    0: t5 = H264_TYPE_SPS;
                    1: t5 = H264_TYPE_PPS;
                    default: t5 = 5'($urandom);
                endcase
                h1 = {($urandom_range(0, 7) == 0), 2'($urandom), t5};
                h2 = 8'($urandom);
            end
            // a short unit stops after at most one header byte
            n_hdr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : 2;
            if (n_hdr >= 1) blob_q.push_back(h1);
            if (n_hdr >= 2) blob_q.push_back(h2);
            if (n_hdr < 2) pay = 0;
            else if (min_len > 0) pay = $urandom_range(0, 60);
            else if ($urandom_range(0, 23) == 0) pay = $urandom_range(100, 300);
            else pay = $urandom_range(0, 12);
            repeat (pay) blob_q.push_back(8'($urandom));
            if (units_left > 0) units_left--;
        end
        if (shape == 1 && blob_q.size() > 3) begin
            cut = $urandom_range(1, blob_q.size() - 1);
            if ($urandom_range(0, 1) == 1) blob_q[cut] = 8'h00;
            else blob_q = blob_q[0:cut-1];
        end
        if (shape == 2) begin
            // start code whose 01 is the final byte
            blob_q.push_back(8'h00);
            blob_q.push_back(8'h00);
            blob_q.push_back(8'h01);
        end
    endfunction

    function automatic t_dir_row beat_row(input logic [7:0] b, input logic last);
        return '{1'b0, REG_MODE, 12'd0, b, last, 1'b0, NO_UNITS};
    endfunction

    function automatic t_dir_row check_row(input logic [7:0] b, input logic last,
                                           input t_ps_locs res);
        return '{1'b0, REG_MODE, 12'd0, b, last, 1'b1, res};
    endfunction

    function automatic t_dir_row cfg_row(input t_reg_idx idx, input logic [11:0] v);
        return '{1'b1, idx, v, 8'h00, 1'b0, 1'b0, NO_UNITS};
    endfunction

    t_dir_row directed [N_DIR];

    initial begin
        int blobs_done;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        res_ch.ready = 1'b0;

        directed = '{
            // after reset: single byte blob, nothing found
            check_row(8'hFF, 1'b1, NO_UNITS),
            // sps and pps, the trailing start code is not seen
            beat_row(8'h00, 1'b0), beat_row(8'h00, 1'b0), beat_row(8'h00, 1'b0),
            beat_row(8'h01, 1'b0), beat_row(8'h67, 1'b0), beat_row(8'h00, 1'b0),
            beat_row(8'h00, 1'b0), beat_row(8'h01, 1'b0), beat_row(8'h68, 1'b0),
            beat_row(8'h00, 1'b0), beat_row(8'h00, 1'b0), beat_row(8'h01, 1'b1),
            // sps larger than its capacity
            cfg_row(REG_SPS_CAP, 12'd4),
            beat_row(8'h00, 1'b0), beat_row(8'h00, 1'b0), beat_row(8'h01, 1'b0),
            beat_row(8'h67, 1'b0), check_row(8'h00, 1'b1, OVERFLOW_ONLY),
            // h.265 vps
            cfg_row(REG_MODE, 12'(MODE_H265)),
            cfg_row(REG_SPS_CAP, 12'd2048),
            beat_row(8'h00, 1'b0), beat_row(8'h00, 1'b0), beat_row(8'h01, 1'b0),
            beat_row(8'h40, 1'b0), beat_row(8'h01, 1'b1),
            cfg_row(REG_MODE, 12'(MODE_AV1)),
            beat_row(8'h5A, 1'b1),
            cfg_row(REG_MODE, 12'(MODE_NONE)),
            check_row(8'hA5, 1'b1, NO_UNITS)
        };

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            if (directed[r].is_cfg) begin
                if (r == 0 || !directed[r-1].is_cfg) settle();
                cfg_write(directed[r].idx, directed[r].val);
            end else begin
                send_beat(directed[r].b, directed[r].last, directed[r].typed, directed[r].res);
            end
        end

        settle();
        retune();
        blobs_done = 0;
        while (rand_items < RAND_ITEMS || blobs_done < MIN_BLOBS) begin
            if ($urandom_range(0, 3) == 0) begin
                settle();
                retune();
            end
            if (blobs_done == 12) begin
                // one blob past the parse limit
                settle();
                cfg_write(REG_MODE, 12'($urandom_range(0, 2)));
                cfg_write(REG_VPS_CAP, 12'd2048);
                cfg_write(REG_SPS_CAP, 12'd2048);
                cfg_write(REG_PPS_CAP, 12'd2048);
                build_blob(MAX_IN + $urandom_range(1, 40));
            end else begin
                build_blob(0);
            end
            case ($urandom_range(0, 3))
                0: gap_on = 1'b0;
                1: begin gap_on = 1'b1; burst_max = 16; gap_max = 6; end
                2: begin gap_on = 1'b1; burst_max = 2; gap_max = 3; end
                default: begin gap_on = 1'b1; burst_max = 40; gap_max = 12; end
            endcase
            foreach (blob_q[i]) begin
                send_beat(blob_q[i], i == blob_q.size() - 1, 1'b0, NO_UNITS);
                rand_items++;
            end
            blobs_done++;
        end

        settle();
        repeat (10) @(negedge i_clk);
        if (mismatch_cnt == 0 && expected_locs.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
